@@ hw/rtl/assert_macros.svh @@
// assertion macros shared by the rtl files
// expects a clock named clock and an active-high reset named reset in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define RRI_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// condition must never be true outside reset
`define RRI_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

@@ hw/rtl/rri_pkg.sv @@
// types, constants and single-precision float functions for the ray/rectangle block
// no dependencies
package rri_pkg;

   typedef logic [31:0] f32_type;
   typedef logic signed [10:0] fexp_type;

   localparam f32_type F32_DNAN  = 32'hFFC0_0000;
   localparam f32_type F32_EPS   = 32'h3400_0000;
   localparam f32_type F32_QBIT  = 32'h0040_0000;

   localparam int DIV_BITS  = 3;
   localparam int DIV_STEPS = 27 / DIV_BITS;
   localparam int DIV_LAT   = DIV_STEPS + 2;

   localparam int QDEPTH = 4;
   localparam int QAW    = 2;

   localparam int CSR_AW = 3;

   typedef enum logic [CSR_AW-1:0] {
      CSR_X_EDGE_A = 3'd0,
      CSR_X_EDGE_B = 3'd1,
      CSR_Y_EDGE_A = 3'd2,
      CSR_Y_EDGE_B = 3'd3,
      CSR_PLANE_Z  = 3'd4
   } csr_idx_type;

   typedef struct packed {
      f32_type origin_x;
      f32_type origin_y;
      f32_type origin_z;
      f32_type dir_x;
      f32_type dir_y;
      f32_type dir_z;
      f32_type t_min;
      f32_type t_max;
   } ray_in_type;

   typedef struct packed {
      logic    hit;
      f32_type t_hit;
      f32_type point_x;
      f32_type point_y;
      f32_type point_z;
      f32_type tex_u;
      f32_type tex_v;
   } rsp_type;

   // queue entry between front and back
   typedef struct packed {
      f32_type origin_x;
      f32_type origin_y;
      f32_type origin_z;
      f32_type dir_x;
      f32_type dir_y;
      f32_type dir_z;
      f32_type t_min;
      f32_type t_max;
      f32_type num;
      logic    dz_zero;
   } ray_type;

   typedef struct packed {
      f32_type lo_x;
      f32_type hi_x;
      f32_type lo_y;
      f32_type hi_y;
      f32_type du;
      f32_type dv;
   } geom_type;

   typedef struct packed {
      fexp_type    e;
      logic [23:0] m;
   } unp_type;

   typedef struct packed {
      logic        special;
      f32_type     sp;
      logic        s;
      fexp_type    e;
      logic [47:0] p;
   } mul_part_type;

   typedef struct packed {
      logic        special;
      f32_type     sp;
      logic        s;
      fexp_type    e;
      logic [23:0] mb;
      logic [24:0] rem;
      logic [26:0] q;
   } div_st_type;

   typedef struct packed {
      f32_type d;
      f32_type lim;
      logic    lt;
   } rc_type;

   typedef struct packed {
      logic    hit;
      f32_type t;
      f32_type px;
      f32_type py;
      f32_type pz;
   } tail_type;

   function automatic logic f_isnan(f32_type a);
      return (&a[30:23]) && (|a[22:0]);
   endfunction

   function automatic logic f_isinf(f32_type a);
      return (&a[30:23]) && !(|a[22:0]);
   endfunction

   function automatic logic f_iszero(f32_type a);
      return a[30:0] == 31'b0;
   endfunction

   function automatic f32_type f_quiet(f32_type a);
      return a | F32_QBIT;
   endfunction

   function automatic f32_type f_abs(f32_type a);
      return {1'b0, a[30:0]};
   endfunction

   function automatic logic f_lt(f32_type a, f32_type b);
      logic r;
      if (f_isnan(a) || f_isnan(b) || (f_iszero(a) && f_iszero(b))) begin
         r = 1'b0;
      end else if (a[31] != b[31]) begin
         r = a[31];
      end else if (!a[31]) begin
         r = a[30:0] < b[30:0];
      end else begin
         r = a[30:0] > b[30:0];
      end
      return r;
   endfunction

   function automatic logic f_le(f32_type a, f32_type b);
      logic eq;
      eq = (a == b) || (f_iszero(a) && f_iszero(b));
      return !f_isnan(a) && !f_isnan(b) && (f_lt(a, b) || eq);
   endfunction

   // nan operand loses, ties keep the first operand
   function automatic f32_type f_min(f32_type a, f32_type b);
      f32_type r;
      if (f_isnan(a)) begin
         r = b;
      end else if (f_isnan(b)) begin
         r = a;
      end else begin
         r = f_lt(b, a) ? b : a;
      end
      return r;
   endfunction

   function automatic f32_type f_max(f32_type a, f32_type b);
      f32_type r;
      if (f_isnan(a)) begin
         r = b;
      end else if (f_isnan(b)) begin
         r = a;
      end else begin
         r = f_lt(a, b) ? b : a;
      end
      return r;
   endfunction

   function automatic logic [4:0] f_lzc24(logic [23:0] m);
      logic [4:0] lz;
      lz = 5'd24;
      for (int i = 0; i < 24; i++) begin
         if (m[i]) lz = 5'(23 - i);
      end
      return lz;
   endfunction

   function automatic logic [4:0] f_lzc27(logic [26:0] m);
      logic [4:0] lz;
      lz = 5'd27;
      for (int i = 0; i < 27; i++) begin
         if (m[i]) lz = 5'(26 - i);
      end
      return lz;
   endfunction

   // finite nonzero operand to exponent and mantissa with leading one at bit 23
   function automatic unp_type f_norm(f32_type a);
      unp_type    u;
      logic [4:0] lz;
      if (a[30:23] != 8'd0) begin
         u.e = fexp_type'({3'b0, a[30:23]});
         u.m = {1'b1, a[22:0]};
      end else begin
         lz  = f_lzc24({1'b0, a[22:0]});
         u.m = {1'b0, a[22:0]} << lz;
         u.e = fexp_type'(1) - fexp_type'({6'b0, lz});
      end
      return u;
   endfunction

   // sig: leading one at bit 26, guard at 2, round and sticky below; value 1.f * 2^(e-127)
   function automatic f32_type f_round(logic s, fexp_type e, logic [26:0] sig);
      logic [53:0] w;
      logic [26:0] m;
      logic [7:0]  ef;
      logic [30:0] body;
      logic        inc;
      fexp_type    sh;
      f32_type     r;
      w = '0;
      m = '0;
      ef = '0;
      sh = '0;
      if (sig == 27'b0) begin
         r = {s, 31'b0};
      end else if (e >= 11'sd255) begin
         r = {s, 8'hFF, 23'b0};
      end else begin
         if (e <= 11'sd0) begin
            sh = fexp_type'(1) - e;
            if (sh > 11'sd26) begin
               m = 27'd1;
            end else begin
               w = {sig, 27'b0} >> sh[4:0];
               m = {w[53:28], w[27] | (|w[26:0])};
            end
            ef = 8'd0;
         end else begin
            m  = sig;
            ef = e[7:0];
         end
         inc  = m[2] & (m[3] | m[1] | m[0]);
         body = {ef, m[25:3]} + {30'b0, inc};
         r    = {s, body};
      end
      return r;
   endfunction

   function automatic f32_type f_add(f32_type a, f32_type b);
      f32_type     x;
      f32_type     y;
      logic [7:0]  ex;
      logic [7:0]  ey;
      logic [7:0]  d;
      logic [23:0] mx;
      logic [23:0] my;
      logic [53:0] w;
      logic [26:0] yy;
      logic [27:0] sum;
      logic [26:0] sig;
      logic [4:0]  lz;
      fexp_type    e;
      f32_type     r;
      r = '0;
      if (f_isnan(a)) begin
         r = f_quiet(a);
      end else if (f_isnan(b)) begin
         r = f_quiet(b);
      end else if (f_isinf(a)) begin
         r = (f_isinf(b) && (a[31] != b[31])) ? F32_DNAN : a;
      end else if (f_isinf(b)) begin
         r = b;
      end else if (f_iszero(a) && f_iszero(b)) begin
         r = {a[31] & b[31], 31'b0};
      end else begin
         if (b[30:0] > a[30:0]) begin
            x = b;
            y = a;
         end else begin
            x = a;
            y = b;
         end
         ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
         ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
         mx = {|x[30:23], x[22:0]};
         my = {|y[30:23], y[22:0]};
         d  = ex - ey;
         if (d > 8'd27) begin
            yy = {26'b0, |my};
         end else begin
            w  = {my, 30'b0} >> d[4:0];
            yy = {w[53:28], w[27] | (|w[26:0])};
         end
         if (x[31] == y[31]) begin
            sum = {1'b0, mx, 3'b0} + {1'b0, yy};
         end else begin
            sum = {1'b0, mx, 3'b0} - {1'b0, yy};
         end
         if (sum == 28'b0) begin
            r = 32'b0;
         end else if (sum[27]) begin
            sig = {sum[27:2], sum[1] | sum[0]};
            e   = fexp_type'({3'b0, ex}) + fexp_type'(1);
            r   = f_round(x[31], e, sig);
         end else begin
            lz  = f_lzc27(sum[26:0]);
            sig = sum[26:0] << lz;
            e   = fexp_type'({3'b0, ex}) - fexp_type'({6'b0, lz});
            r   = f_round(x[31], e, sig);
         end
      end
      return r;
   endfunction

   function automatic f32_type f_sub(f32_type a, f32_type b);
      return f_add(a, f_isnan(b) ? b : {~b[31], b[30:0]});
   endfunction

   // multiply, first half: specials and the raw mantissa product
   function automatic mul_part_type f_mul_a(f32_type a, f32_type b);
      mul_part_type r;
      unp_type      ua;
      unp_type      ub;
      r   = '0;
      r.s = a[31] ^ b[31];
      if (f_isnan(a)) begin
         r.special = 1'b1;
         r.sp      = f_quiet(a);
      end else if (f_isnan(b)) begin
         r.special = 1'b1;
         r.sp      = f_quiet(b);
      end else if ((f_isinf(a) && f_iszero(b)) || (f_iszero(a) && f_isinf(b))) begin
         r.special = 1'b1;
         r.sp      = F32_DNAN;
      end else if (f_isinf(a) || f_isinf(b)) begin
         r.special = 1'b1;
         r.sp      = {r.s, 8'hFF, 23'b0};
      end else if (f_iszero(a) || f_iszero(b)) begin
         r.special = 1'b1;
         r.sp      = {r.s, 31'b0};
      end else begin
         ua  = f_norm(a);
         ub  = f_norm(b);
         r.p = ua.m * ub.m;
         r.e = ua.e + ub.e - fexp_type'(127);
      end
      return r;
   endfunction

   // multiply, second half: normalize and round
   function automatic f32_type f_mul_b(mul_part_type r);
      f32_type z;
      if (r.special) begin
         z = r.sp;
      end else if (r.p[47]) begin
         z = f_round(r.s, r.e + fexp_type'(1), {r.p[47:22], |r.p[21:0]});
      end else begin
         z = f_round(r.s, r.e, {r.p[46:21], |r.p[20:0]});
      end
      return z;
   endfunction

   function automatic f32_type f_mul(f32_type a, f32_type b);
      return f_mul_b(f_mul_a(a, b));
   endfunction

   function automatic div_st_type div_prep(f32_type a, f32_type b);
      div_st_type r;
      unp_type    ua;
      unp_type    ub;
      r   = '0;
      r.s = a[31] ^ b[31];
      if (f_isnan(a)) begin
         r.special = 1'b1;
         r.sp      = f_quiet(a);
      end else if (f_isnan(b)) begin
         r.special = 1'b1;
         r.sp      = f_quiet(b);
      end else if ((f_isinf(a) && f_isinf(b)) || (f_iszero(a) && f_iszero(b))) begin
         r.special = 1'b1;
         r.sp      = F32_DNAN;
      end else if (f_isinf(a) || f_iszero(b)) begin
         r.special = 1'b1;
         r.sp      = {r.s, 8'hFF, 23'b0};
      end else if (f_iszero(a) || f_isinf(b)) begin
         r.special = 1'b1;
         r.sp      = {r.s, 31'b0};
      end else begin
         ua   = f_norm(a);
         ub   = f_norm(b);
         r.mb = ub.m;
         if (ua.m < ub.m) begin
            r.rem = {ua.m, 1'b0};
            r.e   = ua.e - ub.e + fexp_type'(126);
         end else begin
            r.rem = {1'b0, ua.m};
            r.e   = ua.e - ub.e + fexp_type'(127);
         end
      end
      return r;
   endfunction

   // restoring division, DIV_BITS quotient bits per call
   function automatic div_st_type div_step(div_st_type st);
      div_st_type r;
      r = st;
      for (int k = 0; k < DIV_BITS; k++) begin
         if (r.rem >= {1'b0, r.mb}) begin
            r.rem = r.rem - {1'b0, r.mb};
            r.q   = {r.q[25:0], 1'b1};
         end else begin
            r.q   = {r.q[25:0], 1'b0};
         end
         r.rem = {r.rem[23:0], 1'b0};
      end
      return r;
   endfunction

   function automatic f32_type div_finish(div_st_type st);
      return st.special ? st.sp : f_round(st.s, st.e, {st.q[26:1], st.q[0] | (|st.rem)});
   endfunction

   // relative-epsilon compare, first half: difference, limit and plain order
   function automatic rc_type rc_prep(f32_type a, f32_type b);
      rc_type r;
      r.d   = f_sub(a, b);
      r.lim = f_mul(f_max(f_abs(a), f_abs(b)), F32_EPS);
      r.lt  = f_lt(a, b);
      return r;
   endfunction

   function automatic logic rc_eq(rc_type r);
      return f_le(f_abs(r.d), r.lim);
   endfunction

   function automatic logic rc_gt(rc_type r);
      return !rc_eq(r) && !r.lt;
   endfunction

   function automatic logic rc_lt(rc_type r);
      return !rc_eq(r) && r.lt;
   endfunction

endpackage

@@ hw/rtl/rri_queue.sv @@
// short queue of classified rays between front and back
// depends on rri_pkg
module rri_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rri_pkg::ray_type wr_word,
   input  logic             pop,
   output rri_pkg::ray_type rd_word,
   output logic             full,
   output logic             empty
);
   import rri_pkg::*;

   ray_type          ent_ff [QDEPTH];
   logic [QAW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QAW:0]     count_ff, count_in;

   assign full    = count_ff == (QAW+1)'(QDEPTH);
   assign empty   = count_ff == '0;
   assign rd_word = ent_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= wr_word;
      end
   end

endmodule

@@ hw/rtl/rri_front.sv @@
// front end: takes ray words, forms plane_z - origin_z and flags a flat direction
// depends on rri_pkg
module rri_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   input  rri_pkg::ray_in_type req_word,
   output logic                req_full,
   input  rri_pkg::f32_type    plane_z,
   input  logic                q_full,
   output logic                q_push,
   output rri_pkg::ray_type    q_word
);
   import rri_pkg::*;

   logic       hold_v_ff, hold_v_in;
   ray_in_type hold_ff;
   logic       take;

   assign req_full = hold_v_ff && q_full;
   assign take     = req_push && !req_full;
   assign q_push   = hold_v_ff && !q_full;

   always_comb begin
      hold_v_in = hold_v_ff;
      if (take) begin
         hold_v_in = 1'b1;
      end else if (q_push) begin
         hold_v_in = 1'b0;
      end
   end

   always_comb begin
      q_word.origin_x = hold_ff.origin_x;
      q_word.origin_y = hold_ff.origin_y;
      q_word.origin_z = hold_ff.origin_z;
      q_word.dir_x    = hold_ff.dir_x;
      q_word.dir_y    = hold_ff.dir_y;
      q_word.dir_z    = hold_ff.dir_z;
      q_word.t_min    = hold_ff.t_min;
      q_word.t_max    = hold_ff.t_max;
      q_word.num      = f_sub(plane_z, hold_ff.origin_z);
      q_word.dz_zero  = f_iszero(hold_ff.dir_z);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_v_ff <= 1'b0;
      end else begin
         hold_v_ff <= hold_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         hold_ff <= req_word;
      end
   end

endmodule

@@ hw/rtl/rri_fdiv.sv @@
// pipelined float32 divider, DIV_BITS quotient bits per stage
// depends on rri_pkg
module rri_fdiv (
   input  logic             clock,
   input  logic             en,
   input  rri_pkg::f32_type num,
   input  rri_pkg::f32_type den,
   output rri_pkg::f32_type quot
);
   import rri_pkg::*;

   div_st_type st_ff [DIV_STEPS+1];
   f32_type    quot_ff;

   assign quot = quot_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff[0] <= div_prep(num, den);
         for (int k = 0; k < DIV_STEPS; k++) begin
            st_ff[k+1] <= div_step(st_ff[k]);
         end
         quot_ff <= div_finish(st_ff[DIV_STEPS]);
      end
   end

endmodule

@@ hw/rtl/rri_back.sv @@
// back end: t division, hit point, bound tests and texture divisions in one stalling pipe
// depends on rri_pkg and rri_fdiv
module rri_back (
   input  logic              clock,
   input  logic              reset,
   input  rri_pkg::geom_type geom,
   input  rri_pkg::ray_type  q_word,
   input  logic              q_empty,
   output logic              q_pop,
   input  logic              out_full,
   output logic              out_valid,
   output rri_pkg::rsp_type  out_word
);
   import rri_pkg::*;

   logic          adv;
   f32_type       t_q, u_q, v_q;

   logic [DIV_LAT-1:0] va_ff;
   ray_type            ra_ff [DIV_LAT];
   logic [4:0]         vs_ff;
   logic [DIV_LAT-1:0] vb_ff;
   tail_type           rb_ff [DIV_LAT];

   // stage 1
   ray_type       r1_ff;
   f32_type       t1_ff;
   mul_part_type  mpx1_ff, mpy1_ff, mpz1_ff;
   rc_type        rcmin1_ff, rcmax1_ff;
   // stage 2
   ray_type       r2_ff;
   f32_type       t2_ff, mx2_ff, my2_ff, mz2_ff;
   logic          tok2_ff;
   // stage 3
   f32_type       t3_ff, px3_ff, py3_ff, pz3_ff;
   logic          tok3_ff;
   // stage 4
   f32_type       t4_ff, px4_ff, py4_ff, pz4_ff, nu4_ff, nv4_ff;
   logic          tok4_ff;
   rc_type        rcxl4_ff, rcyl4_ff, rcxh4_ff, rcyh4_ff;
   // stage 5
   f32_type       t5_ff, px5_ff, py5_ff, pz5_ff, nu5_ff, nv5_ff;
   logic          hit5_ff;

   assign out_valid = vb_ff[DIV_LAT-1];
   assign adv       = !(out_valid && out_full);
   assign q_pop     = adv && !q_empty;

   rri_fdiv u_tdiv (.clock(clock), .en(adv), .num(q_word.num), .den(q_word.dir_z), .quot(t_q));
   rri_fdiv u_udiv (.clock(clock), .en(adv), .num(nu5_ff), .den(geom.du), .quot(u_q));
   rri_fdiv u_vdiv (.clock(clock), .en(adv), .num(nv5_ff), .den(geom.dv), .quot(v_q));

   always_comb begin
      if (rb_ff[DIV_LAT-1].hit) begin
         out_word.hit     = 1'b1;
         out_word.t_hit   = rb_ff[DIV_LAT-1].t;
         out_word.point_x = rb_ff[DIV_LAT-1].px;
         out_word.point_y = rb_ff[DIV_LAT-1].py;
         out_word.point_z = rb_ff[DIV_LAT-1].pz;
         out_word.tex_u   = u_q;
         out_word.tex_v   = v_q;
      end else begin
         out_word = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= '0;
         vs_ff <= '0;
         vb_ff <= '0;
      end else if (adv) begin
         va_ff <= {va_ff[DIV_LAT-2:0], q_pop};
         vs_ff <= {vs_ff[3:0], va_ff[DIV_LAT-1]};
         vb_ff <= {vb_ff[DIV_LAT-2:0], vs_ff[4]};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ra_ff[0] <= q_word;
         rb_ff[0] <= '{hit: hit5_ff, t: t5_ff, px: px5_ff, py: py5_ff, pz: pz5_ff};
         for (int k = 1; k < DIV_LAT; k++) begin
            ra_ff[k] <= ra_ff[k-1];
            rb_ff[k] <= rb_ff[k-1];
         end

         // products and t window test
         r1_ff     <= ra_ff[DIV_LAT-1];
         t1_ff     <= t_q;
         mpx1_ff   <= f_mul_a(t_q, ra_ff[DIV_LAT-1].dir_x);
         mpy1_ff   <= f_mul_a(t_q, ra_ff[DIV_LAT-1].dir_y);
         mpz1_ff   <= f_mul_a(t_q, ra_ff[DIV_LAT-1].dir_z);
         rcmin1_ff <= rc_prep(t_q, ra_ff[DIV_LAT-1].t_min);
         rcmax1_ff <= rc_prep(t_q, ra_ff[DIV_LAT-1].t_max);

         r2_ff   <= r1_ff;
         t2_ff   <= t1_ff;
         mx2_ff  <= f_mul_b(mpx1_ff);
         my2_ff  <= f_mul_b(mpy1_ff);
         mz2_ff  <= f_mul_b(mpz1_ff);
         tok2_ff <= !r1_ff.dz_zero && rc_gt(rcmin1_ff) && rc_lt(rcmax1_ff);

         // hit point
         t3_ff   <= t2_ff;
         px3_ff  <= f_add(r2_ff.origin_x, mx2_ff);
         py3_ff  <= f_add(r2_ff.origin_y, my2_ff);
         pz3_ff  <= f_add(r2_ff.origin_z, mz2_ff);
         tok3_ff <= tok2_ff;

         // rectangle bounds
         t4_ff    <= t3_ff;
         px4_ff   <= px3_ff;
         py4_ff   <= py3_ff;
         pz4_ff   <= pz3_ff;
         tok4_ff  <= tok3_ff;
         rcxl4_ff <= rc_prep(px3_ff, geom.lo_x);
         rcyl4_ff <= rc_prep(py3_ff, geom.lo_y);
         rcxh4_ff <= rc_prep(px3_ff, geom.hi_x);
         rcyh4_ff <= rc_prep(py3_ff, geom.hi_y);
         nu4_ff   <= f_sub(px3_ff, geom.lo_x);
         nv4_ff   <= f_sub(py3_ff, geom.lo_y);

         t5_ff   <= t4_ff;
         px5_ff  <= px4_ff;
         py5_ff  <= py4_ff;
         pz5_ff  <= pz4_ff;
         nu5_ff  <= nu4_ff;
         nv5_ff  <= nv4_ff;
         hit5_ff <= tok4_ff && rc_gt(rcxl4_ff) && rc_gt(rcyl4_ff)
                    && rc_lt(rcxh4_ff) && rc_lt(rcyh4_ff);
      end
   end

endmodule

@@ hw/rtl/ray_rectangle_intersect.sv @@
// throughput: one ray per cycle unless stalled; the whole back pipe stalls only when the result fifo is full
// the three dividers (t, u, v) are 11-stage pipelines and set most of the latency
// reset: synchronous, active high; csr registers and derived bounds go to zero, queues empty
// the ordered bounds are registered from the csr registers, and the spans from the registered bounds
`include "assert_macros.svh"

module ray_rectangle_intersect (
   input  logic                        clock,
   input  logic                        reset,
   // ray words in
   input  logic                        req_push,
   input  rri_pkg::ray_in_type         req_word,
   output logic                        req_full,
   // result words out
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output rri_pkg::rsp_type            rsp_word,
   // register writes
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [rri_pkg::CSR_AW-1:0]  csr_index,
   input  rri_pkg::f32_type            csr_wdata
);
   import rri_pkg::*;

   // config registers, raw float bit patterns
   f32_type  x_edge_a_ff, x_edge_b_ff, y_edge_a_ff, y_edge_b_ff, plane_z_ff;
   // ordered bounds and spans, derived from the raw edges
   geom_type geom_ff, geom_in;

   logic     q_push, q_pop, q_full, q_empty;
   ray_type  q_wr_word, q_rd_word;

   logic     back_valid;
   rsp_type  back_word;

   // two-word result fifo, decouples the back pipe from rsp_pop
   rsp_type  ofifo_ff [2];
   logic     owr_ptr_ff, ord_ptr_ff;
   logic [1:0] ocnt_ff, ocnt_in;
   logic     ofull, owr, ord;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_edge_a_ff <= '0;
         x_edge_b_ff <= '0;
         y_edge_a_ff <= '0;
         y_edge_b_ff <= '0;
         plane_z_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_idx_type'(csr_index))
            CSR_X_EDGE_A: x_edge_a_ff <= csr_wdata;
            CSR_X_EDGE_B: x_edge_b_ff <= csr_wdata;
            CSR_Y_EDGE_A: y_edge_a_ff <= csr_wdata;
            CSR_Y_EDGE_B: y_edge_b_ff <= csr_wdata;
            CSR_PLANE_Z:  plane_z_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // min/max ordering first, spans from the registered bounds
   always_comb begin
      geom_in.lo_x = f_min(x_edge_a_ff, x_edge_b_ff);
      geom_in.hi_x = f_max(x_edge_a_ff, x_edge_b_ff);
      geom_in.lo_y = f_min(y_edge_a_ff, y_edge_b_ff);
      geom_in.hi_y = f_max(y_edge_a_ff, y_edge_b_ff);
      geom_in.du   = f_sub(geom_ff.hi_x, geom_ff.lo_x);
      geom_in.dv   = f_sub(geom_ff.hi_y, geom_ff.lo_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         geom_ff <= '0;
      end else begin
         geom_ff <= geom_in;
      end
   end

   rri_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_word (req_word),
      .req_full (req_full),
      .plane_z  (plane_z_ff),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_word   (q_wr_word)
   );

   rri_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_word (q_wr_word),
      .pop     (q_pop),
      .rd_word (q_rd_word),
      .full    (q_full),
      .empty   (q_empty)
   );

   rri_back u_back (
      .clock     (clock),
      .reset     (reset),
      .geom      (geom_ff),
      .q_word    (q_rd_word),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .out_full  (ofull),
      .out_valid (back_valid),
      .out_word  (back_word)
   );

   // result fifo
   assign ofull     = ocnt_ff == 2'd2;
   assign owr       = back_valid && !ofull;
   assign rsp_empty = ocnt_ff == 2'd0;
   assign ord       = rsp_pop && !rsp_empty;
   assign rsp_word  = ofifo_ff[ord_ptr_ff];

   always_comb begin
      ocnt_in = ocnt_ff;
      if (owr && !ord) begin
         ocnt_in = ocnt_ff + 2'd1;
      end else if (ord && !owr) begin
         ocnt_in = ocnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ocnt_ff    <= '0;
         owr_ptr_ff <= 1'b0;
         ord_ptr_ff <= 1'b0;
      end else begin
         ocnt_ff <= ocnt_in;
         if (owr) owr_ptr_ff <= ~owr_ptr_ff;
         if (ord) ord_ptr_ff <= ~ord_ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (owr) begin
         ofifo_ff[owr_ptr_ff] <= back_word;
      end
   end

   // checks
   `RRI_ASSERT(a_ofifo_bound, ocnt_ff <= 2'd2, "result fifo count out of range")
   `RRI_NEVER(a_q_overrun, q_push && q_full, "mid queue written while full")
   `RRI_NEVER(a_q_underrun, q_pop && q_empty, "mid queue read while empty")
   `RRI_ASSERT(a_miss_clear, (!rsp_empty && !rsp_word.hit) |-> (rsp_word.t_hit == '0 && rsp_word.tex_u == '0 && rsp_word.tex_v == '0), "miss word carries data")

endmodule
